>>> hw/rtl/rfsa_pkg.sv
// ----------------------------------------------------------------------------
// rfsa_pkg: shared codes for the rectangle free-slot allocator
// Request kinds, result status codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rfsa_pkg;

    // request kinds
    localparam logic REQ_START    = 1'b0;
    localparam logic REQ_ALLOCATE = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_PLACED  = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;
    localparam logic [1:0] STATUS_STARTED = 2'd3;

    // configuration register indexes
    localparam logic CFG_ATLAS_WIDTH  = 1'b0;
    localparam logic CFG_ATLAS_HEIGHT = 1'b1;

    // field widths fixed by the interface
    localparam int SIZE_BITS   = 13;
    localparam int STATUS_BITS = 2;

endpackage

`default_nettype wire

>>> hw/rtl/rfsa_if.sv
// ----------------------------------------------------------------------------
// rfsa_req_if / rfsa_rsp_if: request and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfsa_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [12:0] rect_width;
    logic [12:0] rect_height;

    modport source (output valid, output req_type, output rect_width,
                    output rect_height, input ready);
    modport sink   (input valid, input req_type, input rect_width,
                    input rect_height, output ready);
endinterface

interface rfsa_rsp_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;

    modport source (output valid, output status, output pos_x, output pos_y,
                    input ready);
    modport sink   (input valid, input status, input pos_x, input pos_y,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rfsa_cell.sv
// ----------------------------------------------------------------------------
// rfsa_cell: one free-slot cell of the ring
// Holds one slot word and takes its neighbor's word on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rfsa_cell #(
    parameter int DATA_W = 50
) (
    input  wire logic              clk,
    input  wire logic              shift,
    input  wire logic [DATA_W-1:0] data_in,
    output logic      [DATA_W-1:0] data_out
);

    logic [DATA_W-1:0] slot_reg;

    // take the neighbor's word on a shift, else hold
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            slot_reg <= data_in;
        end
    end

    assign data_out = slot_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rfsa_chain.sv
// ----------------------------------------------------------------------------
// rfsa_chain: ring of free-slot cells
// Cells hand their word toward the head each shift; the tail takes new data.
// ----------------------------------------------------------------------------
`default_nettype none

module rfsa_chain #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 50
) (
    input  wire logic              clk,
    input  wire logic              shift,
    input  wire logic [DATA_W-1:0] tail_in,
    output logic      [DATA_W-1:0] head_out,
    output logic      [DATA_W-1:0] next_out
);

    logic [DATA_W-1:0] link [DEPTH+1];

    assign link[DEPTH] = tail_in;

    // build the row of cells, each fed by its upper neighbor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        rfsa_cell #(.DATA_W(DATA_W)) u_cell (
            .clk      (clk),
            .shift    (shift),
            .data_in  (link[i+1]),
            .data_out (link[i])
        );
    end

    assign head_out = link[0];
    assign next_out = link[1];

endmodule

`default_nettype wire

>>> hw/rtl/rectangle_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// rectangle_free_slot_allocator: guillotine allocator over a sorted free list
// Free slots live in a ring of cells in descending area order; a sequencer
// rotates the ring once per pass to find, delete, check and insert slots.
// ----------------------------------------------------------------------------
// Passes: one item at a time; a start rotates the ring once to insert the root
//   slot, an allocate once to find and delete a slot and, for each remainder,
//   once to check it and once more to insert it if kept (one cell per cycle).
// Reset: control, slot count and result valid registers clear at once and the
//   atlas size registers load 1024; the ring cells hold no reset and are only
//   read below the slot count.
`default_nettype none

module rectangle_free_slot_allocator #(
    parameter int MAX_SLOTS  = 64,
    parameter int COORD_BITS = 12
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [rfsa_pkg::SIZE_BITS-1:0] cfg_wdata,
    rfsa_req_if.sink                       req,
    rfsa_rsp_if.source                     rsp
);

    import rfsa_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int W     = COORD_BITS + 1;
    localparam int AW    = 2 * W;
    localparam int OW    = COORD_BITS + 2;
    localparam int CW    = (SIZE_BITS > W) ? SIZE_BITS : W;
    localparam int IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNTW  = $clog2(MAX_SLOTS + 1);
    localparam int LIMIT = 1 << COORD_BITS;

    typedef struct packed {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [W-1:0]  w;
        logic [W-1:0]  h;
        logic [AW-1:0] area;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_PREP,
        ST_AREA,
        ST_CHECK,
        ST_INSERT,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [SIZE_BITS-1:0]   atlas_w_reg;
    logic [SIZE_BITS-1:0]   atlas_h_reg;
    logic [CNTW-1:0]        count_reg;
    logic [IW-1:0]          tick_reg;
    logic [CNTW-1:0]        pos_reg;
    logic                   found_reg;
    logic                   hit_reg;
    logic                   stop_reg;
    logic                   drop_reg;
    logic                   phase_reg;
    logic                   start_reg;
    logic [CW-1:0]          rw_reg;
    logic [CW-1:0]          rh_reg;
    slot_t                  sel_reg;
    slot_t                  rem_reg;
    slot_t                  hold_reg;
    logic                   out_valid_reg;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic [CB-1:0]          out_x_reg;
    logic [CB-1:0]          out_y_reg;

    logic                   shift;
    slot_t                  tail;
    slot_t                  head;
    slot_t                  nxt;
    logic [SLOT_W-1:0]      head_vec;
    logic [SLOT_W-1:0]      next_vec;
    logic                   in_list;
    logic                   fit_now;
    logic                   hit_now;
    logic                   last_tick;
    logic [CW-1:0]          lim_ext;
    logic [CW-1:0]          aw_ext;
    logic [CW-1:0]          ah_ext;
    slot_t                  root;

    rfsa_chain #(.DEPTH(MAX_SLOTS), .DATA_W(SLOT_W)) u_chain (
        .clk      (clk),
        .shift    (shift),
        .tail_in  (tail),
        .head_out (head_vec),
        .next_out (next_vec)
    );

    assign head = slot_t'(head_vec);
    assign nxt  = slot_t'(next_vec);

    // head cell compared against the scan context
    assign in_list   = CNTW'(tick_reg) < count_reg;
    assign last_tick = tick_reg == IW'(MAX_SLOTS - 1);
    assign fit_now   = !found_reg && in_list &&
                       (CW'(head.w) >= rw_reg) && (CW'(head.h) >= rh_reg);
    assign hit_now   = in_list &&
                       (OW'(rem_reg.x) < OW'(head.x) + OW'(head.w)) &&
                       (OW'(rem_reg.x) + OW'(rem_reg.w) > OW'(head.x)) &&
                       (OW'(rem_reg.y) < OW'(head.y) + OW'(head.h)) &&
                       (OW'(rem_reg.y) + OW'(rem_reg.h) > OW'(head.y));

    // root slot with atlas sizes clamped to the coordinate range
    assign lim_ext = CW'(LIMIT);
    assign aw_ext  = CW'(atlas_w_reg);
    assign ah_ext  = CW'(atlas_h_reg);
    always_comb
    begin
        root      = '0;
        root.w    = (aw_ext > lim_ext) ? lim_ext[W-1:0] : aw_ext[W-1:0];
        root.h    = (ah_ext > lim_ext) ? lim_ext[W-1:0] : ah_ext[W-1:0];
    end

    // rotate the ring during passes and pick the word fed to the tail
    always_comb
    begin
        shift = (state_reg == ST_FIND) || (state_reg == ST_CHECK) ||
                (state_reg == ST_INSERT);
        tail  = head;
        case (state_reg)
            ST_FIND:
            begin
                if (found_reg || fit_now)
                begin
                    tail = nxt;
                end
            end
            ST_INSERT:
            begin
                if (CNTW'(tick_reg) == pos_reg)
                begin
                    tail = rem_reg;
                end
                else if (CNTW'(tick_reg) > pos_reg)
                begin
                    tail = hold_reg;
                end
            end
            default:
            begin
                tail = head;
            end
        endcase
    end

    assign req.ready  = (state_reg == ST_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.pos_x  = out_x_reg;
    assign rsp.pos_y  = out_y_reg;

    // sequencer, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            atlas_w_reg   <= SIZE_BITS'(1024);
            atlas_h_reg   <= SIZE_BITS'(1024);
            count_reg     <= '0;
            tick_reg      <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            drop_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // write configuration
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ATLAS_WIDTH:  atlas_w_reg <= cfg_wdata;
                    CFG_ATLAS_HEIGHT: atlas_h_reg <= cfg_wdata;
                    default:          atlas_w_reg <= atlas_w_reg;
                endcase
            end

            // drop a taken result
            if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        rw_reg    <= CW'(req.rect_width);
                        rh_reg    <= CW'(req.rect_height);
                        tick_reg  <= '0;
                        found_reg <= 1'b0;
                        drop_reg  <= 1'b0;
                        phase_reg <= 1'b0;
                        if (req.req_type == REQ_START)
                        begin
                            start_reg <= 1'b1;
                            count_reg <= '0;
                            rem_reg   <= root;
                            state_reg <= ST_AREA;
                        end
                        else
                        begin
                            start_reg <= 1'b0;
                            state_reg <= ST_FIND;
                        end
                    end
                end

                // find the first fitting slot and delete it on the way
                ST_FIND:
                begin
                    if (fit_now)
                    begin
                        found_reg <= 1'b1;
                        sel_reg   <= head;
                    end
                    tick_reg <= tick_reg + 1'b1;
                    if (last_tick)
                    begin
                        tick_reg <= '0;
                        if (found_reg || fit_now)
                        begin
                            count_reg <= count_reg - 1'b1;
                            state_reg <= ST_PREP;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end

                // form the right remainder, then the bottom one
                ST_PREP:
                begin
                    if (!phase_reg)
                    begin
                        if (CW'(sel_reg.w) > rw_reg)
                        begin
                            rem_reg.x <= sel_reg.x + rw_reg[CB-1:0];
                            rem_reg.y <= sel_reg.y;
                            rem_reg.w <= sel_reg.w - rw_reg[W-1:0];
                            rem_reg.h <= sel_reg.h;
                            state_reg <= ST_AREA;
                        end
                        else
                        begin
                            phase_reg <= 1'b1;
                        end
                    end
                    else if (CW'(sel_reg.h) > rh_reg)
                    begin
                        rem_reg.x <= sel_reg.x;
                        rem_reg.y <= sel_reg.y + rh_reg[CB-1:0];
                        rem_reg.w <= rw_reg[W-1:0];
                        rem_reg.h <= sel_reg.h - rh_reg[W-1:0];
                        state_reg <= ST_AREA;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                // compute the remainder area ahead of the scan
                ST_AREA:
                begin
                    rem_reg.area <= AW'(rem_reg.w) * AW'(rem_reg.h);
                    hit_reg      <= 1'b0;
                    stop_reg     <= 1'b0;
                    pos_reg      <= '0;
                    tick_reg     <= '0;
                    state_reg    <= start_reg ? ST_INSERT : ST_CHECK;
                end

                // check overlap and find the insertion point
                ST_CHECK:
                begin
                    if (hit_now)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (in_list && !stop_reg)
                    begin
                        if (head.area >= rem_reg.area)
                        begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                        else
                        begin
                            stop_reg <= 1'b1;
                        end
                    end
                    tick_reg <= tick_reg + 1'b1;
                    if (last_tick)
                    begin
                        tick_reg <= '0;
                        if (hit_reg || hit_now)
                        begin
                            state_reg <= phase_reg ? ST_DONE : ST_PREP;
                            phase_reg <= 1'b1;
                        end
                        else if (count_reg == CNTW'(MAX_SLOTS))
                        begin
                            drop_reg  <= 1'b1;
                            state_reg <= phase_reg ? ST_DONE : ST_PREP;
                            phase_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_INSERT;
                        end
                    end
                end

                // insert the remainder, delaying later slots by one cell
                ST_INSERT:
                begin
                    hold_reg <= head;
                    tick_reg <= tick_reg + 1'b1;
                    if (last_tick)
                    begin
                        tick_reg  <= '0;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= (phase_reg || start_reg) ? ST_DONE : ST_PREP;
                        phase_reg <= 1'b1;
                    end
                end

                // post the result once the output register is free
                ST_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= '0;
                        out_y_reg     <= '0;
                        if (start_reg)
                        begin
                            out_status_reg <= STATUS_STARTED;
                        end
                        else if (!found_reg)
                        begin
                            out_status_reg <= STATUS_NO_FIT;
                        end
                        else
                        begin
                            out_status_reg <= drop_reg ? STATUS_DROPPED : STATUS_PLACED;
                            out_x_reg      <= sel_reg.x;
                            out_y_reg      <= sel_reg.y;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rfsa_checker.sv
// ----------------------------------------------------------------------------
// rfsa_checker: port-level checks for the rectangle free-slot allocator
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rfsa_checker #(
    parameter int COORD_BITS = 12
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [1:0]            status,
    input wire logic [COORD_BITS-1:0] pos_x,
    input wire logic [COORD_BITS-1:0] pos_y
);

    import rfsa_pkg::*;

    // one item at a time: no new item right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted twice in a row");

    // unplaced results carry a zero position
    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_NO_FIT || status == STATUS_STARTED))
        |-> (pos_x == '0 && pos_y == '0))
        else $error("unplaced result with nonzero position");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(status) && $stable(pos_x) && $stable(pos_y)))
        else $error("stalled result changed");

    // an accept made while no result is pending posts no result straight away
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result posted in the accept cycle");

endmodule

bind rectangle_free_slot_allocator rfsa_checker #(.COORD_BITS(COORD_BITS)) u_rfsa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (rsp.status),
    .pos_x     (rsp.pos_x),
    .pos_y     (rsp.pos_y)
);

`default_nettype wire

>>> tb/rfsa_tb_if.sv
// ----------------------------------------------------------------------------
// rfsa_tb_if: testbench-side records for the allocator channels
// The channel interfaces themselves come from the RTL; this file holds the
// testbench field records used for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

package rfsa_tb_pkg;

    typedef struct packed {
        logic        req_type;
        logic [12:0] rect_width;
        logic [12:0] rect_height;
    } alloc_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
    } alloc_rsp_t;

endpackage

`default_nettype wire

>>> tb/rectangle_free_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// rectangle_free_slot_allocator_tb: self-checking bench for the allocator
// Drives start and allocate items with random bursts, stalls the result side,
// predicts placements with a sorted free-slot list and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_free_slot_allocator_tb;
    import rfsa_pkg::*;
    import rfsa_tb_pkg::*;

    localparam int SLOT_DEPTH = 64;
    localparam int COORD_W    = 12;

    typedef struct {
        int unsigned x;
        int unsigned y;
        int unsigned w;
        int unsigned h;
    } slot_t;

    // predictor of the free list plus queue of expected results
    class placement_board;
        slot_t       slots[$];
        int unsigned atlas_w = 1024;
        int unsigned atlas_h = 1024;
        alloc_rsp_t  pending[$];
        int          errors;

        function bit hits_slot(slot_t r);
            foreach (slots[i])
                if (r.x < slots[i].x + slots[i].w && r.x + r.w > slots[i].x &&
                    r.y < slots[i].y + slots[i].h && r.y + r.h > slots[i].y)
                    return 1;
            return 0;
        endfunction

        // return 0 when the store had no room
        function bit add_remainder(slot_t r);
            int unsigned area;
            int          pos;
            area = r.w * r.h;
            pos  = 0;
            if (hits_slot(r))
                return 1;
            if (slots.size() >= SLOT_DEPTH)
                return 0;
            while (pos < slots.size() && slots[pos].w * slots[pos].h >= area)
                pos++;
            slots.insert(pos, r);
            return 1;
        endfunction

        function void note_request(alloc_req_t q);
            alloc_rsp_t  o;
            slot_t       s;
            slot_t       r;
            int          hit;
            int unsigned lim;
            o   = '0;
            hit = -1;
            lim = 1 << COORD_W;
            if (q.req_type == REQ_START) begin
                s.x = 0;
                s.y = 0;
                s.w = atlas_w > lim ? lim : atlas_w;
                s.h = atlas_h > lim ? lim : atlas_h;
                slots.delete();
                slots.insert(0, s);
                o.status = STATUS_STARTED;
            end
            else begin
                foreach (slots[i])
                    if (hit < 0 && slots[i].w >= q.rect_width &&
                        slots[i].h >= q.rect_height)
                        hit = i;
                if (hit < 0)
                    o.status = STATUS_NO_FIT;
                else begin
                    s = slots[hit];
                    slots.delete(hit);
                    o.status = STATUS_PLACED;
                    if (s.w > q.rect_width) begin
                        r.x = s.x + q.rect_width;
                        r.y = s.y;
                        r.w = s.w - q.rect_width;
                        r.h = s.h;
                        if (!add_remainder(r))
                            o.status = STATUS_DROPPED;
                    end
                    if (s.h > q.rect_height) begin
                        r.x = s.x;
                        r.y = s.y + q.rect_height;
                        r.w = q.rect_width;
                        r.h = s.h - q.rect_height;
                        if (!add_remainder(r))
                            o.status = STATUS_DROPPED;
                    end
                    o.pos_x = s.x[11:0];
                    o.pos_y = s.y[11:0];
                end
            end
            pending.insert(pending.size(), o);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(alloc_rsp_t got);
            alloc_rsp_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d want %0d", got.status, want.status));
            if (got.pos_x !== want.pos_x)
                report($sformatf("pos_x %0d want %0d", got.pos_x, want.pos_x));
            if (got.pos_y !== want.pos_y)
                report($sformatf("pos_y %0d want %0d", got.pos_y, want.pos_y));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [SIZE_BITS-1:0] cfg_wdata;
    int                   sent;
    placement_board       board;

    rfsa_req_if                        req ();
    rfsa_rsp_if #(.COORD_BITS(COORD_W)) rsp ();

    rectangle_free_slot_allocator #(
        .MAX_SLOTS (SLOT_DEPTH),
        .COORD_BITS(COORD_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .req      (req.sink),
        .rsp      (rsp.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #60_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: stall on its own pattern, check on each accepted item
    initial
    begin
        int phase;
        rsp.ready = 1'b0;
        phase     = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
                board.check_result('{rsp.status, rsp.pos_x, rsp.pos_y});
            phase++;
            if ((phase / 300) % 3 == 0)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // hold one item until accepted
    task send_item(alloc_req_t q);
        req.valid       <= 1'b1;
        req.req_type    <= q.req_type;
        req.rect_width  <= q.rect_width;
        req.rect_height <= q.rect_height;
        do
            @(posedge clk);
        while (!req.ready);
        board.note_request(q);
        sent++;
    endtask

    task send_burst_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task alloc(int w, int h);
        send_item('{REQ_ALLOCATE, w[12:0], h[12:0]});
        send_burst_gap();
    endtask

    task start_atlas();
        send_item('{REQ_START, 13'($urandom), 13'($urandom)});
        send_burst_gap();
    endtask

    // wait for every result, let the block settle, then write the atlas size
    task set_atlas(int w, int h);
        req.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ATLAS_WIDTH;
        cfg_wdata <= w[12:0];
        @(posedge clk);
        cfg_index <= CFG_ATLAS_HEIGHT;
        cfg_wdata <= h[12:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        board.atlas_w = w[12:0];
        board.atlas_h = h[12:0];
    endtask

    function int pick_size(int unsigned span);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return span;
            2:       return $urandom_range(0, 8191);
            default: return $urandom_range(1, span > 1 ? span / 2 : 1);
        endcase
    endfunction

    initial
    begin
        int unsigned span;
        board           = new();
        sent            = 0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_ATLAS_WIDTH;
        cfg_wdata       = '0;
        req.valid       = 1'b0;
        req.req_type    = REQ_START;
        req.rect_width  = '0;
        req.rect_height = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: allocate before start, reset atlas, extremes
        alloc(1, 1);
        start_atlas();
        alloc(1024, 1024);
        alloc(1, 1);
        start_atlas();
        alloc(0, 0);
        alloc(1025, 1);
        alloc(8191, 8191);
        alloc(512, 256);
        alloc(512, 256);
        alloc(100, 100);
        set_atlas(8191, 8191);
        start_atlas();
        alloc(4096, 1);
        alloc(4095, 4095);
        alloc(1, 4095);
        set_atlas(0, 0);
        start_atlas();
        alloc(0, 0);
        alloc(1, 0);
        set_atlas(1, 1);
        start_atlas();
        alloc(1, 1);
        alloc(0, 0);

        // random phases over atlas sizes; small ones fill the store
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph % 5)
                0: set_atlas(4096, 4096);
                1: set_atlas($urandom_range(1, 64), $urandom_range(1, 64));
                2: set_atlas($urandom_range(0, 8191), $urandom_range(0, 8191));
                3: set_atlas(8191, 1);
                default: set_atlas($urandom_range(200, 1500), $urandom_range(200, 1500));
            endcase
            span = board.atlas_w > 4096 ? 4096 : board.atlas_w;
            start_atlas();
            repeat (64)
            begin
                if ($urandom_range(0, 40) == 0)
                    start_atlas();
                else if ($urandom_range(0, 1))
                    alloc($urandom_range(1, span < 16 ? 16 : span / 8),
                          $urandom_range(1, 24));
                else
                    alloc(pick_size(span), pick_size(span));
            end
        end

        req.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
